// File: design/bitplane_playfield_pixel_generator_macros.svh
// Assertion macros shared by the pixel generator RTL.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef BITPLANE_PLAYFIELD_PIXEL_GENERATOR_MACROS_SVH
`define BITPLANE_PLAYFIELD_PIXEL_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BPPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BPPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bppg_pkg.sv
// Package for the bitplane playfield pixel generator: sizes, codes and helpers.
// Used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bppg_pkg;

  localparam int MAX_PLANES      = 6;
  localparam int PALETTE_SIZE    = 32;
  localparam int PIXELS_PER_WORD = 16;

  localparam int PAL_AW      = $clog2(PALETTE_SIZE);
  localparam int SLOT_W      = $clog2(PIXELS_PER_WORD);
  localparam int PLANE_CNT_W = $clog2(MAX_PLANES + 1);
  localparam int PF_W        = (MAX_PLANES + 1) / 2;
  localparam int PF2_OFFSET  = 8;

  localparam int COLOR_W    = 12;
  localparam int WORD_W     = 16;
  localparam int RGB_W      = 24;
  localparam int TARGET_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  typedef enum logic {
    ACT_PALETTE = 1'b0,
    ACT_PLANE   = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANES    = 2'd0,
    REG_DUAL      = 2'd1,
    REG_PF2_FIRST = 2'd2
  } cfg_reg_t;

  // Each 4-bit component is repeated into both nibbles of its byte.
  function automatic logic [RGB_W-1:0] expand_rgb(input logic [COLOR_W-1:0] c);
    expand_rgb = {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
  endfunction

endpackage

// File: design/bppg_channels.sv
// Valid/ready channel interfaces for the pixel generator: request input,
// pixel output and configuration write. Depends on bppg_pkg.
`timescale 1ns / 1ps

interface bppg_in_if import bppg_pkg::*; ();
  logic                valid;
  logic                ready;
  action_t             action;
  logic [TARGET_W-1:0] target;
  logic [WORD_W-1:0]   value;

  modport source (output valid, action, target, value, input ready);
  modport sink (input valid, action, target, value, output ready);
endinterface

interface bppg_out_if import bppg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RGB_W-1:0]  pixel_rgb;
  logic [SLOT_W-1:0] pixel_slot;
  logic              last_pixel;

  modport source (output valid, pixel_rgb, pixel_slot, last_pixel, input ready);
  modport sink (input valid, pixel_rgb, pixel_slot, last_pixel, output ready);
endinterface

interface bppg_cfg_if import bppg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/bitplane_playfield_pixel_generator.sv
// Top level of the bitplane playfield pixel generator.
// Depends on bppg_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "bitplane_playfield_pixel_generator_macros.svh"

// Palette writes and writes to the other planes are taken while idle and give no pixels.
// A write to an enabled plane 0 starts a run of sixteen pixels, leftmost first: one
// palette memory read per cycle while the output drains; each pixel passes
// through the palette read register and then the output register, and a
// stalled output holds the run in place.
// New requests are refused from the plane-0 write until the last pixel of its
// run has moved into the output register. After reset every palette entry
// reads as zero until written.
module bitplane_playfield_pixel_generator import bppg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bppg_in_if.sink     in_ch,
  bppg_out_if.source  out_ch,
  bppg_cfg_if.sink    cfg_ch
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PIXELS_PER_WORD - 1);
  localparam int IDX_W = (MAX_PLANES > PAL_AW) ? MAX_PLANES : PAL_AW;

  logic [2:0]             planes_r;
  logic                   dual_r;
  logic                   pf2_first_r;

  logic [WORD_W-1:0]      plane_r [MAX_PLANES];
  logic [COLOR_W-1:0]     pal_mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] pal_valid_r;

  logic                   running_r, running_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic                   pend_r, pend_nxt;
  logic [SLOT_W-1:0]      pend_slot_r;
  logic [COLOR_W-1:0]     rd_color_r;
  logic                   rd_valid_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [RGB_W-1:0]       out_rgb_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic                   out_last_r;

  logic [PLANE_CNT_W-1:0] eff_planes;
  logic                   in_fire;
  logic                   pal_we;
  logic                   plane_we;
  logic                   start;
  logic                   load;
  logic                   issue;
  logic [MAX_PLANES-1:0]  bit_vec;
  logic [PF_W-1:0]        pf1;
  logic [PF_W-1:0]        pf2;
  logic [IDX_W-1:0]       idx_wide;
  logic [PAL_AW-1:0]      rd_addr;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r    <= '0;
      dual_r      <= 1'b0;
      pf2_first_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_PLANES:    planes_r    <= cfg_ch.data;
        REG_DUAL:      dual_r      <= cfg_ch.data[0];
        REG_PF2_FIRST: pf2_first_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign eff_planes = (32'(planes_r) > MAX_PLANES) ? PLANE_CNT_W'(MAX_PLANES)
                                                   : PLANE_CNT_W'(planes_r);

  assign in_ch.ready = !running_r && !pend_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pal_we      = in_fire && (in_ch.action == ACT_PALETTE)
                       && (32'(in_ch.target) < PALETTE_SIZE);
  assign plane_we    = in_fire && (in_ch.action == ACT_PLANE)
                       && (32'(in_ch.target) < 32'(eff_planes));
  assign start       = plane_we && (in_ch.target == '0);

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_PLANES; j++) begin
      if (!rst_n) begin
        plane_r[j] <= '0;
      end else if (plane_we && (32'(in_ch.target) == j)) begin
        plane_r[j] <= in_ch.value;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_PLANES; j++) begin
      bit_vec[j] = (j < 32'(eff_planes)) && plane_r[j][LAST_SLOT - slot_r];
    end
    for (int k = 0; k < PF_W; k++) begin
      pf1[k] = bit_vec[2 * k];
      pf2[k] = (2 * k + 1 < MAX_PLANES) ? bit_vec[2 * k + 1] : 1'b0;
    end
  end

  assign idx_wide = IDX_W'(bit_vec);

  always_comb begin
    if (!dual_r) begin
      rd_addr = idx_wide[PAL_AW-1:0];
    end else if (pf1 == '0 && pf2 == '0) begin
      rd_addr = '0;
    end else if (pf2_first_r ? (pf2 != '0) : (pf1 == '0)) begin
      rd_addr = PAL_AW'(pf2) + PAL_AW'(PF2_OFFSET);
    end else begin
      rd_addr = PAL_AW'(pf1);
    end
  end

  assign load  = pend_r && (!out_valid_r || out_ch.ready);
  assign issue = running_r && (!pend_r || load);

  always_comb begin
    running_nxt = running_r;
    slot_nxt    = slot_r;
    if (start) begin
      running_nxt = 1'b1;
      slot_nxt    = '0;
    end else if (issue) begin
      slot_nxt = slot_r + 1'b1;
      if (slot_r == LAST_SLOT) begin
        running_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (issue) begin
      pend_nxt = 1'b1;
    end else if (load) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      slot_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pal_valid_r <= '0;
    end else begin
      running_r   <= running_nxt;
      slot_r      <= slot_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (pal_we) begin
        pal_valid_r[in_ch.target[PAL_AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[in_ch.target[PAL_AW-1:0]] <= in_ch.value[COLOR_W-1:0];
    end
    if (issue) begin
      rd_color_r  <= pal_mem[rd_addr];
      rd_valid_r  <= pal_valid_r[rd_addr];
      pend_slot_r <= slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rgb_r  <= rd_valid_r ? expand_rgb(rd_color_r) : '0;
      out_slot_r <= pend_slot_r;
      out_last_r <= (pend_slot_r == LAST_SLOT);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_rgb  = out_rgb_r;
  assign out_ch.pixel_slot = out_slot_r;
  assign out_ch.last_pixel = out_last_r;

  `BPPG_ASSERT_IMP(a_no_request_in_run, in_fire, !running_r && !pend_r, "request during run")
  `BPPG_ASSERT_NXT(a_start_slot, start, running_r && slot_r == '0, "run did not start at slot 0")
  `BPPG_ASSERT_NXT(a_run_ends, issue && slot_r == LAST_SLOT, !running_r && pend_r, "run end lost")
  `BPPG_ASSERT_NXT(a_pend_holds, pend_r && !load, pend_r && $stable(pend_slot_r), "read data lost")
  `BPPG_ASSERT_IMP(a_last_flag, out_valid_r, out_last_r == (out_slot_r == LAST_SLOT), "bad last flag")

endmodule
